### rtl/crc_chk_pkg.sv
// ----------------------------------------------------------------------------
// crc_chk_pkg
// Shared types, constants and the byte-wise CRC-32 update for the settings
// record checker.
// ----------------------------------------------------------------------------
package crc_chk_pkg;

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] MAGIC_RESET   = 32'h5250_3234;
  localparam logic [31:0] VERSION_RESET = 32'h0000_0001;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_EXPECTED_MAGIC   = 1'b0,
    CFG_EXPECTED_VERSION = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    VERDICT_OK           = 2'd0,
    VERDICT_BAD_MAGIC    = 2'd1,
    VERDICT_BAD_VERSION  = 2'd2,
    VERDICT_CRC_MISMATCH = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
  } result_t;

  // Reflected CRC-32, one byte, unrolled over eight bit steps
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

### rtl/crc_chk_if.sv
// ----------------------------------------------------------------------------
// crc_chk_if
// Valid/ready channels of the record checker: record bytes, results and
// register writes.
// ----------------------------------------------------------------------------
interface crc_chk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;
  logic       starts_record;

  modport source (output valid, output record_byte, output starts_record,
                  input ready);
  modport sink   (input valid, input record_byte, input starts_record,
                  output ready);
endinterface

interface crc_chk_result_if;
  logic                 valid;
  logic                 ready;
  crc_chk_pkg::verdict_t verdict;
  logic [31:0]          computed_crc;
  logic [31:0]          stored_crc;

  modport source (output valid, output verdict, output computed_crc,
                  output stored_crc, input ready);
  modport sink   (input valid, input verdict, input computed_crc,
                  input stored_crc, output ready);
endinterface

interface crc_chk_cfg_if;
  logic                    valid;
  logic                    ready;
  crc_chk_pkg::cfg_index_t index;
  logic [31:0]             data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/config_record_checker.sv
// ----------------------------------------------------------------------------
// config_record_checker
// Checks a stored settings record byte by byte: reflected CRC-32 over the
// magic, version and payload, then a magic/version/CRC verdict.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  cfg      in   register index, 32-bit write data (always ready)
//  rec      in   record_byte, starts_record
//  res      out  verdict, computed_crc, stored_crc (one beat per record)
//
//  One byte per cycle while rec.ready is up: the CRC byte update and field
//  gathering run between the record state and the result register. The last
//  CRC byte's result is registered into an output register, or into one skid
//  entry while the output holds; results queue there and rec.ready drops only while both hold.
//  rst (synchronous) closes any record and restores the register defaults.
// ----------------------------------------------------------------------------
module config_record_checker #(
  parameter int NUM_SCALES = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  crc_chk_cfg_if.sink             cfg,
  crc_chk_byte_if.sink            rec,
  crc_chk_result_if.source        res
);

  localparam int BodyLen = 8 + 8 * NUM_SCALES;
  localparam int LastPos = BodyLen + 3;
  localparam int PosW    = $clog2(LastPos + 1);

  logic [31:0]     expected_magic;
  logic [31:0]     expected_version;

  logic [31:0]     crc_register, crc_register_next;
  logic [PosW-1:0] byte_position, byte_position_next;
  logic [31:0]     gathered_magic, gathered_magic_next;
  logic [31:0]     gathered_version, gathered_version_next;
  logic [31:0]     gathered_crc, gathered_crc_next;
  logic            record_active, record_active_next;

  crc_chk_pkg::result_t out_data, skid_data, new_result;
  logic                 out_valid, skid_valid, new_valid;

  logic            rec_fire;
  logic            res_fire;
  logic [31:0]     crc_base, magic_base, version_base, scrc_base;
  logic [PosW-1:0] pos;
  logic            active;
  logic [31:0]     lane_byte;
  logic [31:0]     computed;

  assign cfg.ready = 1'b1;
  assign rec.ready = !skid_valid;
  assign rec_fire  = rec.valid && rec.ready;
  assign res_fire  = out_valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= crc_chk_pkg::MAGIC_RESET;
      expected_version <= crc_chk_pkg::VERSION_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        crc_chk_pkg::CFG_EXPECTED_MAGIC:   expected_magic   <= cfg.data;
        crc_chk_pkg::CFG_EXPECTED_VERSION: expected_version <= cfg.data;
        default: ;
      endcase
    end
  end

  // A start beat wipes the record before the byte is applied
  always_comb begin
    crc_base     = rec.starts_record ? crc_chk_pkg::CRC_INIT : crc_register;
    magic_base   = rec.starts_record ? 32'd0 : gathered_magic;
    version_base = rec.starts_record ? 32'd0 : gathered_version;
    scrc_base    = rec.starts_record ? 32'd0 : gathered_crc;
    pos          = rec.starts_record ? '0 : byte_position;
    active       = rec.starts_record || record_active;
    lane_byte    = {24'd0, rec.record_byte} << {pos[1:0], 3'b000};

    crc_register_next     = crc_register;
    byte_position_next    = byte_position;
    gathered_magic_next   = gathered_magic;
    gathered_version_next = gathered_version;
    gathered_crc_next     = gathered_crc;
    record_active_next    = record_active;
    new_valid             = 1'b0;
    computed              = ~crc_base;
    new_result.verdict      = crc_chk_pkg::VERDICT_OK;
    new_result.computed_crc = computed;
    new_result.stored_crc   = scrc_base | lane_byte;

    if (rec_fire && active) begin
      crc_register_next     = (pos < PosW'(BodyLen))
                              ? crc_chk_pkg::crc32_byte(crc_base, rec.record_byte)
                              : crc_base;
      gathered_magic_next   = (pos < PosW'(4)) ? (magic_base | lane_byte) : magic_base;
      gathered_version_next = (pos >= PosW'(4) && pos < PosW'(8))
                              ? (version_base | lane_byte) : version_base;
      gathered_crc_next     = (pos >= PosW'(BodyLen)) ? (scrc_base | lane_byte) : scrc_base;
      byte_position_next    = pos + 1'b1;
      record_active_next    = 1'b1;

      if (pos == PosW'(LastPos)) begin
        new_valid = 1'b1;
        priority if (magic_base != expected_magic)
          new_result.verdict = crc_chk_pkg::VERDICT_BAD_MAGIC;
        else if (version_base != expected_version)
          new_result.verdict = crc_chk_pkg::VERDICT_BAD_VERSION;
        else if (computed != new_result.stored_crc)
          new_result.verdict = crc_chk_pkg::VERDICT_CRC_MISMATCH;
        else
          new_result.verdict = crc_chk_pkg::VERDICT_OK;

        crc_register_next     = crc_chk_pkg::CRC_INIT;
        byte_position_next    = '0;
        gathered_magic_next   = 32'd0;
        gathered_version_next = 32'd0;
        gathered_crc_next     = 32'd0;
        record_active_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_register     <= crc_chk_pkg::CRC_INIT;
      byte_position    <= '0;
      gathered_magic   <= 32'd0;
      gathered_version <= 32'd0;
      gathered_crc     <= 32'd0;
      record_active    <= 1'b0;
    end else begin
      crc_register     <= crc_register_next;
      byte_position    <= byte_position_next;
      gathered_magic   <= gathered_magic_next;
      gathered_version <= gathered_version_next;
      gathered_crc     <= gathered_crc_next;
      record_active    <= record_active_next;
    end
  end

  // Output register with one skid entry; no new result while the skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || res_fire) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= new_valid;
        end
      end else if (new_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || res_fire) begin
      out_data <= skid_valid ? skid_data : new_result;
    end
    if (new_valid && out_valid && !res_fire) begin
      skid_data <= new_result;
    end
  end

  assign res.valid        = out_valid;
  assign res.verdict      = out_data.verdict;
  assign res.computed_crc = out_data.computed_crc;
  assign res.stored_crc   = out_data.stored_crc;

endmodule

### tb/config_record_checker_test.sv
// ----------------------------------------------------------------------------
// config_record_checker_test
// Streams settings records through the checker, byte by byte, and compares
// each verdict beat with an in-bench tracker of the CRC, the gathered words
// and the record framing. Covers restarts, stray bytes and register changes.
// ----------------------------------------------------------------------------
module config_record_checker_test;
  import crc_chk_pkg::*;

  localparam int NUM_SCALES    = 4;
  localparam int BODY_BYTES    = 8 + 8 * NUM_SCALES;
  localparam int RECORD_BYTES  = BODY_BYTES + 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int LIMIT_CYCLES  = 400000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crc_chk_cfg_if    cfg_ch ();
  crc_chk_byte_if   rec_ch ();
  crc_chk_result_if res_ch ();

  config_record_checker #(.NUM_SCALES(NUM_SCALES)) DUT (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .rec (rec_ch),
    .res (res_ch)
  );

  always #5 clk = ~clk;

  // tracker state, mirrors what the checker should hold
  logic [31:0] want_magic   = MAGIC_RESET;
  logic [31:0] want_version = VERSION_RESET;
  logic [31:0] crc_acc      = CRC_INIT;
  logic [9:0]  rec_pos      = '0;
  logic [31:0] magic_acc    = '0;
  logic [31:0] version_acc  = '0;
  logic [31:0] stored_acc   = '0;
  logic        in_record    = 1'b0;

  result_t pending_verdicts[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bytes_sent  = 0;
  int fail_count  = 0;
  int cycle_count = 0;
  int verdict_hits[4] = '{0, 0, 0, 0};

  // reflected CRC-32, fed LSB first one bit at a time
  function automatic logic [31:0] fold_crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_record();
    crc_acc     = CRC_INIT;
    rec_pos     = '0;
    magic_acc   = '0;
    version_acc = '0;
    stored_acc  = '0;
    in_record   = 1'b0;
  endfunction

  function automatic void track_record_byte(logic [7:0] b, logic s);
    result_t     r;
    logic [31:0] computed;
    if (s) begin
      clear_record();
      in_record = 1'b1;
    end
    if (!in_record) return;
    if (rec_pos < BODY_BYTES) crc_acc = fold_crc_byte(crc_acc, b);
    if (rec_pos < 4) magic_acc[rec_pos[1:0] * 8 +: 8] = b;
    else if (rec_pos < 8) version_acc[rec_pos[1:0] * 8 +: 8] = b;
    else if (rec_pos >= BODY_BYTES) stored_acc[rec_pos[1:0] * 8 +: 8] = b;
    if (rec_pos < RECORD_BYTES - 1) begin
      rec_pos = rec_pos + 1'b1;
      return;
    end
    computed = ~crc_acc;
    if (magic_acc != want_magic) r.verdict = VERDICT_BAD_MAGIC;
    else if (version_acc != want_version) r.verdict = VERDICT_BAD_VERSION;
    else if (computed != stored_acc) r.verdict = VERDICT_CRC_MISMATCH;
    else r.verdict = VERDICT_OK;
    r.computed_crc = computed;
    r.stored_crc   = stored_acc;
    pending_verdicts.push_back(r);
    clear_record();
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endfunction

  // verdict beat checker
  always @(posedge clk) begin : check_verdicts
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict beat with nothing outstanding");
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 32'(want.verdict), 32'(res_ch.verdict));
        check_field("computed_crc", want.computed_crc, res_ch.computed_crc);
        check_field("stored_crc", want.stored_crc, res_ch.stored_crc);
        verdict_hits[want.verdict]++;
      end
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge with valid still up
  task automatic send_byte(input logic [7:0] b, input logic s);
    while ($urandom_range(99) < tx_idle_pct) begin
      rec_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rec_ch.valid         <= 1'b1;
    rec_ch.record_byte   <= b;
    rec_ch.starts_record <= s;
    @(posedge clk);
    while (!rec_ch.ready) @(posedge clk);
    track_record_byte(b, s);
    bytes_sent++;
    @(negedge clk);
  endtask

  // sends the first len bytes of a record; crc_flip corrupts the stored CRC
  task automatic send_record(input logic [31:0] magic, input logic [31:0] version,
                             input fill_t fill, input logic [31:0] crc_flip,
                             input int len);
    logic [7:0]  rec_bytes[RECORD_BYTES];
    logic [31:0] crc;
    for (int i = 0; i < 4; i++) begin
      rec_bytes[i]     = magic[i * 8 +: 8];
      rec_bytes[4 + i] = version[i * 8 +: 8];
    end
    for (int i = 8; i < BODY_BYTES; i++) begin
      case (fill)
        FILL_ZERO: rec_bytes[i] = 8'h00;
        FILL_ONES: rec_bytes[i] = 8'hFF;
        default:   rec_bytes[i] = 8'($urandom());
      endcase
    end
    crc = CRC_INIT;
    for (int i = 0; i < BODY_BYTES; i++) crc = fold_crc_byte(crc, rec_bytes[i]);
    crc = ~crc ^ crc_flip;
    for (int i = 0; i < 4; i++) rec_bytes[BODY_BYTES + i] = crc[i * 8 +: 8];
    for (int i = 0; i < len; i++) send_byte(rec_bytes[i], i == 0);
  endtask

  task automatic send_stray_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom()), 1'b0);
  endtask

  task automatic settle();
    rec_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_EXPECTED_MAGIC:   want_magic   = value;
      CFG_EXPECTED_VERSION: want_version = value;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] nonzero_mask();
    logic [31:0] m;
    m = $urandom();
    return (m == 0) ? 32'h1 : m;
  endfunction

  // stray bytes before any start, restarts, bytes after the CRC field
  task automatic test_framing();
    send_stray_bytes(5);
    send_record(want_magic, want_version, FILL_RANDOM, '0, 17);
    send_record(want_magic, want_version, FILL_RANDOM, '0, RECORD_BYTES - 1);
    send_record(want_magic, want_version, FILL_RANDOM, '0, RECORD_BYTES);
    send_stray_bytes(6);
    send_record(want_magic, want_version, FILL_RANDOM, 32'h8000_0000, RECORD_BYTES);
  endtask

  task automatic test_default_registers();
    send_record(MAGIC_RESET, VERSION_RESET, FILL_ZERO, '0, RECORD_BYTES);
    send_record(MAGIC_RESET, VERSION_RESET, FILL_ONES, '0, RECORD_BYTES);
  endtask

  // magic beats version beats CRC
  task automatic test_verdict_order();
    send_record(want_magic ^ 32'h1, want_version, FILL_RANDOM, '0, RECORD_BYTES);
    send_record(want_magic, want_version ^ 32'h8000_0000, FILL_RANDOM, '0, RECORD_BYTES);
    send_record(want_magic, want_version, FILL_RANDOM, 32'h0000_0001, RECORD_BYTES);
    send_record(~want_magic, ~want_version, FILL_RANDOM, 32'hFFFF_FFFF, RECORD_BYTES);
    send_record(want_magic, ~want_version, FILL_RANDOM, 32'h0001_0000, RECORD_BYTES);
  endtask

  task automatic test_register_extremes();
    write_register(CFG_EXPECTED_MAGIC, 32'h0000_0000);
    write_register(CFG_EXPECTED_VERSION, 32'h0000_0000);
    send_record(32'h0, 32'h0, FILL_ZERO, '0, RECORD_BYTES);
    send_record(32'hFFFF_FFFF, 32'h0, FILL_RANDOM, '0, RECORD_BYTES);
    write_register(CFG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
    write_register(CFG_EXPECTED_VERSION, 32'hFFFF_FFFF);
    send_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, FILL_ONES, '0, RECORD_BYTES);
    send_record(32'hFFFF_FFFF, 32'h0, FILL_RANDOM, '0, RECORD_BYTES);
  endtask

  // just under half well-formed records, the rest corrupted, cut short or noise
  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [31:0] magic,
                                     input logic [31:0] version,
                                     input int budget);
    int    start_count;
    int    pick;
    fill_t fill;
    write_register(CFG_EXPECTED_MAGIC, magic);
    write_register(CFG_EXPECTED_VERSION, version);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start_count = bytes_sent;
    while (bytes_sent - start_count < budget) begin
      pick = $urandom_range(99);
      fill = ($urandom_range(9) == 0) ? fill_t'($urandom_range(2)) : FILL_RANDOM;
      if (pick < 45)
        send_record(want_magic, want_version, fill, '0, RECORD_BYTES);
      else if (pick < 55)
        send_record(want_magic, want_version, fill, 32'h1 << $urandom_range(31),
                    RECORD_BYTES);
      else if (pick < 63)
        send_record(want_magic ^ nonzero_mask(), want_version, fill, '0, RECORD_BYTES);
      else if (pick < 71)
        send_record(want_magic, want_version ^ nonzero_mask(), fill, '0, RECORD_BYTES);
      else if (pick < 78)
        send_record($urandom(), $urandom(), fill, $urandom(), RECORD_BYTES);
      else if (pick < 88)
        send_record(want_magic, want_version, fill, '0,
                    $urandom_range(RECORD_BYTES - 1, 1));
      else
        send_stray_bytes($urandom_range(6, 1));
    end
  endtask

  initial begin
    rec_ch.valid         = 1'b0;
    rec_ch.record_byte   = 8'h00;
    rec_ch.starts_record = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_EXPECTED_MAGIC;
    cfg_ch.data          = '0;
    res_ch.ready         = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    tx_idle_pct = 26;
    rx_idle_pct = 48;
    test_framing();
    test_default_registers();
    test_verdict_order();
    test_register_extremes();
    test_random_traffic(26, 48, $urandom(), VERSION_RESET, 380);
    test_random_traffic(48, 26, MAGIC_RESET, $urandom(), 380);
    test_random_traffic(0, 0, $urandom(), $urandom(), 380);
    settle();

    $display("%0d record bytes driven over several register settings", bytes_sent);
    $display("verdicts checked: ok %0d, bad magic %0d, bad version %0d, crc %0d",
             verdict_hits[0], verdict_hits[1], verdict_hits[2], verdict_hits[3]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
